// ===== src/pda_pkg.sv =====
package pda_pkg;

   localparam int NUM_STATES_DEF  = 32;
   localparam int TABLE_SIZE_DEF  = 64;
   localparam int STACK_DEPTH_DEF = 1024;
   localparam int PUSH_MAX_DEF    = 4;
   localparam int EPS_LIMIT_DEF   = 10;

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_START  = 2'd1,
      OP_FEED   = 2'd2,
      OP_FINISH = 2'd3
   } op_type;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NO_MATCH = 2'd1;
   localparam logic [1:0] ST_DEAD     = 2'd2;

   localparam logic REG_INITIAL_STATE = 1'b0;
   localparam logic REG_ACCEPT_MASK   = 1'b1;

   typedef struct packed {
      logic [1:0]  operation;
      logic [5:0]  slot;
      logic        entry_valid;
      logic [4:0]  source_state;
      logic [7:0]  symbol;
      logic        is_epsilon;
      logic        needs_empty;
      logic [7:0]  top_symbol;
      logic [4:0]  next_state;
      logic [2:0]  push_count;
      logic [31:0] push_symbols;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        accepted;
      logic [4:0]  current_state;
      logic [10:0] stack_depth;
      logic        overflow;
      logic [3:0]  epsilon_steps;
   } rsp_type;

   typedef struct packed {
      logic [4:0]  src;
      logic [7:0]  sym;
      logic        eps;
      logic        empty;
      logic [7:0]  top;
      logic [4:0]  next;
      logic [2:0]  count;
      logic [31:0] pushes;
   } tbl_entry_type;

   typedef struct packed {
      logic capture;
      logic load;
      logic start;
      logic mark_dead_seen;
      logic top_rd;
      logic scan_init;
      logic scan_step;
      logic apply;
      logic push;
      logic set_dead;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       dead;
      logic       match;
      logic       scan_end;
      logic       push_done;
      logic       eps_full;
      logic       rsp_free;
   } sts_type;

endpackage

// ===== src/pushdown_automaton_recognizer_core.sv =====
// table-driven deterministic pushdown recognizer
// requests enter on req_valid/req_ready with a req_type payload; each request
// gives exactly one result on rsp_valid/rsp_ready with a rsp_type payload.
// operations: load writes one transition slot, start begins a new string,
// feed applies one symbol, finish applies epsilon moves and reports accept.
// load and start go from dispatch straight to the result. feed runs the scan
// and then the move: the scan reads one table entry per cycle from the table
// memory, from slot 0 upward, until a slot matches or all TABLE_SIZE slots
// are read; a matched slot is applied and its push symbols written one by one.
// finish repeats scan, apply and push, plus a reread of the stack top, for
// each epsilon move, up to EPS_LIMIT moves.
// one request is worked at a time; a new request is taken while the previous
// result still waits in the output register, but its own result holds until
// rsp_ready frees that register.
// configuration: initial_state at byte 0, accept_mask at byte 4, to be written
// by the user only while idle, unenforced by the block; pready is always high.
// reset: all table slots invalid, empty stack, state 0, dead and overflow clear.
// the stack memory is not cleared and needs no clearing pass.
module pushdown_automaton_recognizer_core #(
   parameter int NUM_STATES  = pda_pkg::NUM_STATES_DEF,
   parameter int TABLE_SIZE  = pda_pkg::TABLE_SIZE_DEF,
   parameter int STACK_DEPTH = pda_pkg::STACK_DEPTH_DEF,
   parameter int PUSH_MAX    = pda_pkg::PUSH_MAX_DEF,
   parameter int EPS_LIMIT   = pda_pkg::EPS_LIMIT_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pda_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pda_pkg::rsp_type rsp_data,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [2:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   logic [4:0]       init_ff, init_in;
   logic [31:0]      mask_ff, mask_in;
   logic             csr_wr;
   pda_pkg::cmd_type cmd;
   pda_pkg::sts_type sts;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      init_in = init_ff;
      mask_in = mask_ff;
      if (csr_wr) begin
         if (csr_paddr[2] == pda_pkg::REG_INITIAL_STATE) begin
            init_in = csr_pwdata[4:0];
         end else begin
            mask_in = csr_pwdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff <= '0;
         mask_ff <= '0;
      end else begin
         init_ff <= init_in;
         mask_ff <= mask_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == pda_pkg::REG_ACCEPT_MASK) ? mask_ff
                                                                  : {27'd0, init_ff};

   pda_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   pda_dp #(
      .NUM_STATES  (NUM_STATES),
      .TABLE_SIZE  (TABLE_SIZE),
      .STACK_DEPTH (STACK_DEPTH),
      .PUSH_MAX    (PUSH_MAX),
      .EPS_LIMIT   (EPS_LIMIT)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_data      (req_data),
      .initial_state (init_ff),
      .accept_mask   (mask_ff),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data)
   );

endmodule

// ===== src/pda_ram.sv =====
module pda_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/pda_ctrl.sv =====
module pda_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pda_pkg::sts_type  sts,
   output pda_pkg::cmd_type  cmd
);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_DISP   = 7'b0000010,
      S_SCAN   = 7'b0000100,
      S_APPLY  = 7'b0001000,
      S_PUSH   = 7'b0010000,
      S_RESCAN = 7'b0100000,
      S_RESP   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DISP;
            end
         end
         S_DISP: begin
            priority if (sts.op == pda_pkg::OP_LOAD) begin
               cmd.load = 1'b1;
               state_in = S_RESP;
            end else if (sts.op == pda_pkg::OP_START) begin
               cmd.start = 1'b1;
               state_in  = S_RESP;
            end else if (sts.dead) begin
               cmd.mark_dead_seen = 1'b1;
               state_in           = S_RESP;
            end else begin
               cmd.top_rd    = 1'b1;
               cmd.scan_init = 1'b1;
               state_in      = S_SCAN;
            end
         end
         S_SCAN: begin
            priority if (sts.match) begin
               state_in = S_APPLY;
            end else if (sts.scan_end) begin
               cmd.set_dead = (sts.op == pda_pkg::OP_FEED);
               state_in     = S_RESP;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         S_APPLY: begin
            cmd.apply = 1'b1;
            state_in  = S_PUSH;
         end
         S_PUSH: begin
            priority if (!sts.push_done) begin
               cmd.push = 1'b1;
            end else if (sts.op == pda_pkg::OP_FEED || sts.eps_full) begin
               state_in = S_RESP;
            end else begin
               state_in = S_RESCAN;
            end
         end
         S_RESCAN: begin
            cmd.top_rd    = 1'b1;
            cmd.scan_init = 1'b1;
            state_in      = S_SCAN;
         end
         S_RESP: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

endmodule

// ===== src/pda_dp.sv =====
module pda_dp #(
   parameter int NUM_STATES  = pda_pkg::NUM_STATES_DEF,
   parameter int TABLE_SIZE  = pda_pkg::TABLE_SIZE_DEF,
   parameter int STACK_DEPTH = pda_pkg::STACK_DEPTH_DEF,
   parameter int PUSH_MAX    = pda_pkg::PUSH_MAX_DEF,
   parameter int EPS_LIMIT   = pda_pkg::EPS_LIMIT_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  pda_pkg::req_type req_data,
   input  logic [4:0]       initial_state,
   input  logic [31:0]      accept_mask,
   input  pda_pkg::cmd_type cmd,
   output pda_pkg::sts_type sts,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pda_pkg::rsp_type rsp_data
);

   localparam int TAW = $clog2(TABLE_SIZE);
   localparam int SAW = $clog2(STACK_DEPTH);
   localparam int SPW = $clog2(STACK_DEPTH + 1);
   localparam int EW  = $clog2(EPS_LIMIT + 1);
   localparam int TW  = $bits(pda_pkg::tbl_entry_type);

   pda_pkg::req_type       req_ff, req_in;
   logic [SPW-1:0]         sp_ff, sp_in;
   logic [4:0]             cs_ff, cs_in;
   logic                   dead_ff, dead_in;
   logic                   ovf_ff, ovf_in;
   logic [TAW:0]           idx_ff, idx_in;
   logic                   pend_ff, pend_in;
   logic [TAW-1:0]         cmpi_ff, cmpi_in;
   logic [TABLE_SIZE-1:0]  vld_ff, vld_in;
   pda_pkg::tbl_entry_type ent_ff, ent_in;
   logic [2:0]             cnt_ff, cnt_in;
   logic [EW-1:0]          steps_ff, steps_in;
   logic [1:0]             stat_ff, stat_in;
   pda_pkg::rsp_type       rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic [31:0]            slot_w;
   logic [TAW-1:0]         slot_idx;
   logic                   slot_ok;
   pda_pkg::tbl_entry_type wr_ent, rd_ent;
   logic [TW-1:0]          tbl_rdata;
   logic [7:0]             stk_rdata;
   logic [SPW-1:0]         sp_m1;
   logic [2:0]             pi;
   logic [7:0]             push_sym;
   logic                   sp_full;
   logic                   is_fin;
   logic                   match;
   logic [31:0]            cs_w, sp_w, steps_w;

   assign slot_w   = 32'(req_ff.slot);
   assign slot_idx = slot_w[TAW-1:0];
   assign slot_ok  = slot_w < 32'(TABLE_SIZE);

   always_comb begin
      wr_ent        = '0;
      wr_ent.src    = req_ff.source_state;
      wr_ent.sym    = req_ff.symbol;
      wr_ent.eps    = req_ff.is_epsilon;
      wr_ent.empty  = req_ff.needs_empty;
      wr_ent.top    = req_ff.top_symbol;
      wr_ent.next   = req_ff.next_state;
      wr_ent.count  = (32'(req_ff.push_count) > 32'(PUSH_MAX)) ? 3'(PUSH_MAX)
                                                              : req_ff.push_count;
      wr_ent.pushes = req_ff.push_symbols;
   end

   pda_ram #(.WIDTH(TW), .DEPTH(TABLE_SIZE)) u_tbl (
      .clock (clock),
      .we    (cmd.load && slot_ok),
      .waddr (slot_idx),
      .wdata (wr_ent),
      .re    (cmd.scan_step),
      .raddr (idx_ff[TAW-1:0]),
      .rdata (tbl_rdata)
   );

   assign rd_ent  = pda_pkg::tbl_entry_type'(tbl_rdata);
   assign sp_m1   = sp_ff - SPW'(1);
   assign sp_full = (sp_ff == SPW'(STACK_DEPTH));
   assign pi      = cnt_ff - 3'd1;
   // only four bytes are held, higher symbols read as zero
   assign push_sym = pi[2] ? 8'd0 : ent_ff.pushes[{pi[1:0], 3'b000} +: 8];

   pda_ram #(.WIDTH(8), .DEPTH(STACK_DEPTH)) u_stk (
      .clock (clock),
      .we    (cmd.push && !sp_full),
      .waddr (sp_ff[SAW-1:0]),
      .wdata (push_sym),
      .re    (cmd.top_rd),
      .raddr (sp_m1[SAW-1:0]),
      .rdata (stk_rdata)
   );

   assign is_fin = (req_ff.operation == pda_pkg::OP_FINISH);
   assign match  = pend_ff && vld_ff[cmpi_ff] && (rd_ent.eps == is_fin)
                   && (rd_ent.src == cs_ff) && (is_fin || rd_ent.sym == req_ff.symbol)
                   && (rd_ent.empty ? (sp_ff == '0)
                                    : (sp_ff != '0 && rd_ent.top == stk_rdata));

   assign cs_w    = 32'(cs_ff);
   assign sp_w    = 32'(sp_ff);
   assign steps_w = 32'(steps_ff);

   always_comb begin
      req_in       = req_ff;
      sp_in        = sp_ff;
      cs_in        = cs_ff;
      dead_in      = dead_ff;
      ovf_in       = ovf_ff;
      idx_in       = idx_ff;
      pend_in      = pend_ff;
      cmpi_in      = cmpi_ff;
      vld_in       = vld_ff;
      ent_in       = ent_ff;
      cnt_in       = cnt_ff;
      steps_in     = steps_ff;
      stat_in      = stat_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (cmd.capture) begin
         req_in   = req_data;
         stat_in  = pda_pkg::ST_OK;
         steps_in = '0;
      end
      if (cmd.load && slot_ok) begin
         vld_in[slot_idx] = req_ff.entry_valid;
      end
      if (cmd.start) begin
         sp_in   = '0;
         dead_in = 1'b0;
         cs_in   = initial_state;
      end
      if (cmd.mark_dead_seen) begin
         stat_in = pda_pkg::ST_DEAD;
      end
      if (cmd.set_dead) begin
         dead_in = 1'b1;
         stat_in = pda_pkg::ST_NO_MATCH;
      end
      if (cmd.scan_init) begin
         idx_in  = '0;
         pend_in = 1'b0;
      end
      if (cmd.scan_step) begin
         idx_in  = idx_ff + (TAW+1)'(1);
         cmpi_in = idx_ff[TAW-1:0];
         pend_in = 1'b1;
      end
      if (cmd.apply) begin
         ent_in = rd_ent;
         cnt_in = rd_ent.count;
         cs_in  = rd_ent.next;
         if (!rd_ent.empty && sp_ff != '0) begin
            sp_in = sp_m1;
         end
         if (is_fin) begin
            steps_in = steps_ff + EW'(1);
         end
      end
      if (cmd.push) begin
         cnt_in = cnt_ff - 3'd1;
         if (sp_full) begin
            ovf_in = 1'b1;
         end else begin
            sp_in = sp_ff + SPW'(1);
         end
      end
      if (cmd.rsp_load) begin
         rsp_in.status        = stat_ff;
         rsp_in.accepted      = is_fin && stat_ff == pda_pkg::ST_OK
                                && cs_w < 32'(NUM_STATES) && accept_mask[cs_ff];
         rsp_in.current_state = cs_ff;
         rsp_in.stack_depth   = sp_w[10:0];
         rsp_in.overflow      = ovf_ff;
         rsp_in.epsilon_steps = steps_w[3:0];
         rsp_valid_in         = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff        <= '0;
         cs_ff        <= '0;
         dead_ff      <= 1'b0;
         ovf_ff       <= 1'b0;
         vld_ff       <= '0;
         pend_ff      <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sp_ff        <= sp_in;
         cs_ff        <= cs_in;
         dead_ff      <= dead_in;
         ovf_ff       <= ovf_in;
         vld_ff       <= vld_in;
         pend_ff      <= pend_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      cmpi_ff  <= cmpi_in;
      ent_ff   <= ent_in;
      cnt_ff   <= cnt_in;
      steps_ff <= steps_in;
      stat_ff  <= stat_in;
      rsp_ff   <= rsp_in;
   end

   always_comb begin
      sts           = '0;
      sts.op        = req_ff.operation;
      sts.dead      = dead_ff;
      sts.match     = match;
      sts.scan_end  = pend_ff && idx_ff == (TAW+1)'(TABLE_SIZE);
      sts.push_done = (cnt_ff == 3'd0);
      sts.eps_full  = (steps_w == 32'(EPS_LIMIT));
      sts.rsp_free  = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_sp_range: assert property (@(posedge clock) disable iff (reset)
      sp_w <= 32'(STACK_DEPTH))
      else $error("stack pointer beyond depth");

   a_ovf_sticky: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |=> ovf_ff)
      else $error("overflow flag cleared");

   a_no_push_on_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_step |-> !cmd.push && !cmd.apply)
      else $error("stack update during table scan");

endmodule

// ===== bench/pda_checker.sv =====
module pda_checker
   import pda_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output int          fail_count,
   output int          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int N_SLOTS   = 64;
   localparam int MAX_DEPTH = 1024;
   localparam int MAX_PUSH  = 4;
   localparam int MAX_EPS   = 10;

   typedef struct {
      bit            used;
      tbl_entry_type e;
   } slot_rec;

   slot_rec    rules[N_SLOTS];
   bit [7:0]   pstack[MAX_DEPTH];
   int         depth;
   bit [4:0]   state_q;
   bit         dead_q;
   bit         ovf_q;
   bit [4:0]   init_state;
   bit [31:0]  accept_bits;
   rsp_type    expected_rsps[$];

   function automatic int match_rule(bit eps, bit [7:0] sym);
      for (int i = 0; i < N_SLOTS; i++) begin
         if (rules[i].used && rules[i].e.eps == eps && rules[i].e.src == state_q &&
             (eps || rules[i].e.sym == sym)) begin
            if (rules[i].e.empty) begin
               if (depth == 0) return i;
            end else if (depth > 0 && pstack[depth-1] == rules[i].e.top) begin
               return i;
            end
         end
      end
      return -1;
   endfunction

   function automatic void take_rule(int k);
      tbl_entry_type t;
      t = rules[k].e;
      if (!t.empty && depth > 0) depth--;
      for (int i = int'(t.count) - 1; i >= 0; i--) begin
         if (depth < MAX_DEPTH) begin
            pstack[depth] = t.pushes[8*i +: 8];
            depth++;
         end else begin
            ovf_q = 1;
         end
      end
      state_q = t.next;
   endfunction

   function automatic rsp_type run_request(req_type r);
      rsp_type o;
      int      k;
      o = '0;
      case (op_type'(r.operation))
         OP_LOAD: begin
            rules[r.slot].used     = r.entry_valid;
            rules[r.slot].e.src    = r.source_state;
            rules[r.slot].e.sym    = r.symbol;
            rules[r.slot].e.eps    = r.is_epsilon;
            rules[r.slot].e.empty  = r.needs_empty;
            rules[r.slot].e.top    = r.top_symbol;
            rules[r.slot].e.next   = r.next_state;
            rules[r.slot].e.count  = (r.push_count > MAX_PUSH) ? 3'(MAX_PUSH) : r.push_count;
            rules[r.slot].e.pushes = r.push_symbols;
         end
         OP_START: begin
            depth   = 0;
            dead_q  = 0;
            state_q = init_state;
         end
         OP_FEED: begin
            if (dead_q) begin
               o.status = ST_DEAD;
            end else begin
               k = match_rule(0, r.symbol);
               if (k < 0) begin
                  dead_q   = 1;
                  o.status = ST_NO_MATCH;
               end else begin
                  take_rule(k);
               end
            end
         end
         default: begin
            if (dead_q) begin
               o.status = ST_DEAD;
            end else begin
               while (o.epsilon_steps < MAX_EPS) begin
                  k = match_rule(1, 8'h0);
                  if (k < 0) break;
                  take_rule(k);
                  o.epsilon_steps++;
               end
               o.accepted = accept_bits[state_q];
            end
         end
      endcase
      o.current_state = state_q;
      o.stack_depth   = 11'(depth);
      o.overflow      = ovf_q;
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         foreach (rules[i]) rules[i].used = 0;
         depth       = 0;
         state_q     = 0;
         dead_q      = 0;
         ovf_q       = 0;
         init_state  = 0;
         accept_bits = 0;
         expected_rsps.delete();
         fail_count  = 0;
         pending_count = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite) begin
            if (csr_paddr[2] == REG_ACCEPT_MASK) accept_bits = csr_pwdata;
            else init_state = csr_pwdata[4:0];
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected result %p", rsp_data);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("result mismatch: expected %p actual %p", want, rsp_data);
               end
            end
         end
         if (req_valid && req_ready) expected_rsps.push_back(run_request(req_data));
         pending_count = expected_rsps.size();
      end
   end

endmodule

// ===== bench/tb_pushdown_automaton_recognizer_core.sv =====
module tb_pushdown_automaton_recognizer_core;
   import pda_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   rsp_type     rsp_data;
   logic        csr_psel = 0;
   logic        csr_penable = 0;
   logic        csr_pwrite = 0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          fail_count;
   int          pending_count;
   int          send_idle_pct;
   int          recv_idle_pct;
   bit          hold_rsp;
   int          quiet_cycles;

   pushdown_automaton_recognizer_core i_dut (.*);

   pda_checker i_checker (
      .clock, .reset, .req_valid, .req_ready, .req_data, .rsp_valid, .rsp_ready,
      .rsp_data, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .fail_count, .pending_count
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      if (hold_rsp) rsp_ready <= 0;
      else rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // watchdog on acceptance activity
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles > 20000) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // valid stays up across back-to-back requests, dropped only for idles
   task automatic send_request(req_type r);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid <= 1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (800) @(posedge clock);
   endtask

   task automatic write_csr(bit [2:0] addr, bit [31:0] value);
      csr_psel   <= 1;
      csr_pwrite <= 1;
      csr_paddr  <= addr;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel    <= 0;
      csr_penable <= 0;
      csr_pwrite  <= 0;
   endtask

   function automatic req_type mk_load(bit [5:0] s, bit v, bit [4:0] src, bit [7:0] sym,
                                       bit eps, bit emp, bit [7:0] top, bit [4:0] nxt,
                                       bit [2:0] cnt, bit [31:0] pu);
      req_type r;
      r = '{OP_LOAD, s, v, src, sym, eps, emp, top, nxt, cnt, pu};
      return r;
   endfunction

   function automatic req_type mk_op(op_type op, bit [7:0] sym);
      req_type r;
      r = ($bits(req_type))'({$urandom, $urandom, $urandom});
      r.operation = op;
      r.symbol    = sym;
      return r;
   endfunction

   // balanced-parens style grammar over symbols 8'h28/8'h29 plus one epsilon move, in slots 0 to 4
   task automatic load_grammar();
      send_request(mk_load(0, 1, 0, 8'h28, 0, 1, 0, 1, 1, 32'h41));
      send_request(mk_load(1, 1, 1, 8'h28, 0, 0, 8'h41, 1, 2, 32'h4141));
      send_request(mk_load(2, 1, 1, 8'h29, 0, 0, 8'h41, 1, 0, 0));
      send_request(mk_load(3, 1, 1, 8'h00, 1, 1, 0, 2, 0, 0));
      send_request(mk_load(4, 1, 2, 8'h28, 0, 1, 0, 1, 1, 32'h41));
   endtask

   task automatic random_phase(int n);
      req_type r;
      int      pick;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            r = ($bits(req_type))'({$urandom, $urandom, $urandom});
            r.operation = OP_LOAD;
            r.slot      = 6'($urandom_range(5, 63));
            r.source_state = 5'($urandom_range(0, 3));
            if ($urandom_range(1)) r.symbol = 8'(8'h28 + $urandom_range(1));
         end else if (pick < 16) begin
            r = mk_op(OP_START, 0);
         end else if (pick < 24) begin
            r = mk_op(OP_FINISH, 0);
         end else if (pick < 30) begin
            r = mk_op(OP_FEED, 8'($urandom));
         end else begin
            r = mk_op(OP_FEED, 8'(8'h28 + (($urandom_range(99) < 55) ? 0 : 1)));
         end
         send_request(r);
      end
   endtask

   initial begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_rsp      = 0;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      write_csr(3'd0, 32'd1);
      write_csr(3'd4, 32'h0000_0004);

      // directed: empty-table feed/finish, extremes, loads incl. oversized push
      send_request(mk_op(OP_FEED, 8'hff));
      send_request(mk_op(OP_FEED, 8'h00));
      send_request(mk_op(OP_FINISH, 0));
      send_request(mk_op(OP_START, 0));
      send_request(mk_op(OP_FINISH, 0));
      load_grammar();
      send_request(mk_load(63, 1, 31, 8'hff, 0, 0, 8'hff, 31, 7, 32'hffff_ffff));
      send_request(mk_load(62, 0, 31, 8'hff, 1, 1, 8'hff, 31, 3, 32'h0));
      send_request(mk_op(OP_START, 0));
      send_request(mk_op(OP_FEED, 8'h28));
      send_request(mk_op(OP_FEED, 8'h28));
      send_request(mk_op(OP_FEED, 8'h29));
      send_request(mk_op(OP_FEED, 8'h29));
      send_request(mk_op(OP_FINISH, 0));
      send_request(mk_op(OP_FEED, 8'h29));
      send_request(mk_op(OP_FEED, 8'h29));
      send_request(mk_op(OP_FINISH, 0));
      // overflow: self-loop pops one and pushes four per symbol until full
      send_request(mk_load(5, 1, 3, 8'h55, 0, 1, 0, 3, 4, 32'h1234_5678));
      send_request(mk_load(6, 1, 3, 8'h55, 0, 0, 8'h78, 3, 4, 32'h1234_5678));
      wait_drained();
      write_csr(3'd0, 32'd3);
      send_request(mk_op(OP_START, 0));
      for (int i = 0; i < 345; i++) send_request(mk_op(OP_FEED, 8'h55));
      send_request(mk_op(OP_FINISH, 0));
      send_request(mk_load(5, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_request(mk_load(6, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      wait_drained();

      write_csr(3'd0, 32'd0);
      write_csr(3'd4, 32'hffff_ffff);
      send_idle_pct = 32;
      recv_idle_pct = 84;
      random_phase(100);

      // long receiver hold while requests keep coming
      hold_rsp = 1;
      fork
         begin
            repeat (400) @(posedge clock);
            hold_rsp = 0;
         end
         random_phase(6);
      join
      wait_drained();

      write_csr(3'd0, 32'd31);
      write_csr(3'd4, 32'h8000_0006);
      send_idle_pct = 84;
      recv_idle_pct = 32;
      random_phase(100);
      wait_drained();

      write_csr(3'd0, 32'd2);
      write_csr(3'd4, 32'h0000_0002);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_phase(100);

      wait_drained();
      if (fail_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end
endmodule
